FILE: rtl/kwsc_pkg.sv
package kwsc_pkg;

    // Field widths of one transaction.
    localparam int WORD_W      = 16;
    localparam int KEY_COUNT   = 4;
    localparam int NIB_W       = 4;
    localparam int KEY_IDX_W   = $clog2(KEY_COUNT);
    localparam int HDR_CNT_W   = KEY_IDX_W + 1;

    // Header capture is complete once this many keys are stored.
    localparam logic [HDR_CNT_W-1:0] HDR_DONE = HDR_CNT_W'(KEY_COUNT);
    // Data position after which the keys advance.
    localparam logic [KEY_IDX_W-1:0] LAST_PHASE = KEY_IDX_W'(KEY_COUNT - 1);

    // Direction register codes.
    localparam logic DIR_DECRYPT = 1'b0;
    localparam logic DIR_ENCRYPT = 1'b1;

    typedef logic [KEY_COUNT-1:0][WORD_W-1:0] key_arr_t;

    // Per-key increments applied before the nibble transpose (key 0 in the low slot).
    localparam key_arr_t KEY_STEP = {16'd19, 16'd23, 16'd41, 16'd67};

    // Payload of an input transaction.
    typedef struct packed {
        logic [WORD_W-1:0] data_word;
        logic              first_word;
        logic              in_last;
    } in_item_t;

    // Payload of a result transaction.
    typedef struct packed {
        logic [WORD_W-1:0] out_word;
        logic              is_key_word;
        logic              out_last;
    } out_item_t;

    // Add the step constants, then transpose the 4x4 nibble matrix:
    // nibble n of new key p is nibble p of old key n.
    function automatic key_arr_t advance_keys(input key_arr_t k);
        key_arr_t s;
        key_arr_t t;
        for (int p = 0; p < KEY_COUNT; p++)
        begin
            s[p] = k[p] + KEY_STEP[p];
        end
        for (int p = 0; p < KEY_COUNT; p++)
        begin
            for (int n = 0; n < KEY_COUNT; n++)
            begin
                t[p][n*NIB_W +: NIB_W] = s[n][p*NIB_W +: NIB_W];
            end
        end
        return t;
    endfunction

endpackage

FILE: rtl/kwsc_if.sv
// Input channel: one word of the structure per transaction.
interface kwsc_in_if;
    import kwsc_pkg::*;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] data_word;
    logic              first_word;
    logic              in_last;

    modport source (output valid, output data_word, output first_word, output in_last,
                    input ready);
    modport sink   (input valid, input data_word, input first_word, input in_last,
                    output ready);
endinterface

// Output channel: one transformed word per transaction.
interface kwsc_out_if;
    import kwsc_pkg::*;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] out_word;
    logic              is_key_word;
    logic              out_last;

    modport source (output valid, output out_word, output is_key_word, output out_last,
                    input ready);
    modport sink   (input valid, input out_word, input is_key_word, input out_last,
                    output ready);
endinterface

FILE: rtl/kwsc_in_stage.sv
module kwsc_in_stage
    import kwsc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    kwsc_in_if.sink  din,
    input  logic     advance,
    output logic     s1_valid,
    output in_item_t s1_item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     take;

    // The register can load when empty or when its item moves on this cycle.
    assign din.ready = !valid_reg || advance;
    assign take      = din.valid && din.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload capture.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.data_word  <= din.data_word;
            item_reg.first_word <= din.first_word;
            item_reg.in_last    <= din.in_last;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_item  = item_reg;

endmodule

FILE: rtl/kwsc_key_unit.sv
module kwsc_key_unit
    import kwsc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      fire,
    input  in_item_t  item,
    input  logic      direction,
    output out_item_t result
);

    key_arr_t              key_regs_reg;
    key_arr_t              key_regs_next;
    logic [HDR_CNT_W-1:0]  header_count_reg;
    logic [HDR_CNT_W-1:0]  header_count_next;
    logic [KEY_IDX_W-1:0]  key_phase_reg;
    logic [KEY_IDX_W-1:0]  key_phase_next;
    logic [HDR_CNT_W-1:0]  hc_eff;
    logic [KEY_IDX_W-1:0]  ph_eff;
    logic [WORD_W-1:0]     cur_key;

    // A first-word mark restarts header capture and the data phase.
    assign hc_eff  = item.first_word ? '0 : header_count_reg;
    assign ph_eff  = item.first_word ? '0 : key_phase_reg;
    assign cur_key = key_regs_reg[ph_eff];

    // Key capture in the header, add or subtract the key afterwards.
    always_comb
    begin
        key_regs_next      = key_regs_reg;
        header_count_next  = hc_eff;
        key_phase_next     = ph_eff;
        result.out_last    = item.in_last;
        if (hc_eff < HDR_DONE)
        begin
            key_regs_next[hc_eff[KEY_IDX_W-1:0]] = item.data_word;
            header_count_next  = hc_eff + HDR_CNT_W'(1);
            result.out_word    = item.data_word;
            result.is_key_word = 1'b1;
        end
        else
        begin
            unique case (direction)
                DIR_ENCRYPT: result.out_word = item.data_word + cur_key;
                DIR_DECRYPT: result.out_word = item.data_word - cur_key;
                default:     result.out_word = item.data_word;
            endcase
            result.is_key_word = 1'b0;
            if (ph_eff == LAST_PHASE)
            begin
                key_regs_next = advance_keys(key_regs_reg);
            end
            key_phase_next = ph_eff + KEY_IDX_W'(1);
        end
    end

    // Key state commits only when the item moves into the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_regs_reg     <= '0;
            header_count_reg <= '0;
            key_phase_reg    <= '0;
        end
        else if (fire)
        begin
            key_regs_reg     <= key_regs_next;
            header_count_reg <= header_count_next;
            key_phase_reg    <= key_phase_next;
        end
    end

    // The header count never passes the number of keys.
    assert property (@(posedge clk) disable iff (!rst_n)
        header_count_reg <= HDR_DONE)
        else $error("header count out of range");

    // The data phase only moves once the header is complete.
    assert property (@(posedge clk) disable iff (!rst_n)
        (header_count_reg != HDR_DONE) |-> (key_phase_reg == '0))
        else $error("key phase moved during header capture");

    // A first-word item always becomes key 0.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item.first_word) |=> (header_count_reg == HDR_CNT_W'(1)))
        else $error("first word did not restart header capture");

    // Without a consumed item the key state stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> ($stable(key_regs_reg) && $stable(key_phase_reg)))
        else $error("key state changed without a transaction");

endmodule

FILE: rtl/keyed_word_stream_cipher_unit.sv
// Keyed word stream cipher unit.
//
// The din channel carries one 16-bit word per transaction, with a first-word
// mark that restarts a structure and a last mark that is only passed along.
// The first four words after a restart are stored as keys and returned
// unchanged with is_key_word set; every later word gets its position's key
// added (direction 1) or subtracted (direction 0), and the keys advance after
// every fourth data word. The dout channel returns one transaction per input.
// The user must write the direction register through cfg_we / cfg_wdata only
// while idle; the block itself does not enforce this.
// An accepted word is registered in the input register, moves on into the
// result register once that is empty or being drained, and waits there until
// dout takes it. Throughput is one word per clock while dout does not stall,
// set by the single add and key update between the two registers.
// When the receiver stalls, the result register holds its transaction and the
// input register still takes one more word before din.ready drops.
// Reset clears the keys, header count, key phase and direction to zero and
// empties both registers; no clearing pass is needed.
module keyed_word_stream_cipher_unit
    import kwsc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    kwsc_in_if.sink   din,
    kwsc_out_if.source dout,
    input  logic      cfg_we,
    input  logic      cfg_wdata
);

    logic      direction_reg;
    logic      s1_valid;
    in_item_t  s1_item;
    logic      advance;
    out_item_t result;
    logic      res_valid_reg;
    logic      res_valid_next;
    out_item_t res_item_reg;

    // Input register.
    kwsc_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .din      (din),
        .advance  (advance),
        .s1_valid (s1_valid),
        .s1_item  (s1_item)
    );

    // Key state and word transform.
    kwsc_key_unit u_key_unit (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (advance),
        .item      (s1_item),
        .direction (direction_reg),
        .result    (result)
    );

    // Direction register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= DIR_DECRYPT;
        end
        else if (cfg_we)
        begin
            direction_reg <= cfg_wdata;
        end
    end

    // An item moves on when the result register is empty or being drained.
    assign advance = s1_valid && (!res_valid_reg || dout.ready);

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (advance)
        begin
            res_valid_next = 1'b1;
        end
        else if (dout.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_item_reg <= result;
        end
    end

    assign dout.valid       = res_valid_reg;
    assign dout.out_word    = res_item_reg.out_word;
    assign dout.is_key_word = res_item_reg.is_key_word;
    assign dout.out_last    = res_item_reg.out_last;

endmodule

FILE: sim/tb_keyed_word_stream_cipher_unit.sv
module tb_keyed_word_stream_cipher_unit;
    import kwsc_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_WORDS   = 325;
    localparam int RANDOM_PHASES = 4;

    // Predicts the cipher output for every accepted word and checks the results in order.
    class word_cipher_scoreboard;
        logic [WORD_W-1:0] keys [KEY_COUNT];
        int                keys_captured;
        logic [1:0]        data_pos;
        logic              direction;
        out_item_t         pending_words [$];
        int                errors;

        function new();
            for (int i = 0; i < KEY_COUNT; i++)
            begin
                keys[i] = '0;
            end
            keys_captured = 0;
            data_pos = '0;
            direction = DIR_DECRYPT;
            errors = 0;
        endfunction

        function void set_direction(input logic dir);
            direction = dir;
        endfunction

        function int outstanding();
            return pending_words.size();
        endfunction

        // Bump each key by its constant, then swap nibble rows and columns.
        function void rotate_keys();
            logic [WORD_W-1:0] bumped [KEY_COUNT];
            bumped[0] = keys[0] + 16'd67;
            bumped[1] = keys[1] + 16'd41;
            bumped[2] = keys[2] + 16'd23;
            bumped[3] = keys[3] + 16'd19;
            for (int p = 0; p < KEY_COUNT; p++)
            begin
                for (int n = 0; n < KEY_COUNT; n++)
                begin
                    keys[p][n*NIB_W +: NIB_W] = bumped[n][p*NIB_W +: NIB_W];
                end
            end
        endfunction

        // Work out the result of one accepted input transaction.
        function void note_word(input in_item_t word_in);
            out_item_t predicted;
            logic [WORD_W-1:0] key;
            if (word_in.first_word)
            begin
                keys_captured = 0;
                data_pos = '0;
            end
            predicted.out_last = word_in.in_last;
            if (keys_captured < KEY_COUNT)
            begin
                // Header words are stored as keys and passed through.
                keys[keys_captured] = word_in.data_word;
                keys_captured++;
                predicted.out_word = word_in.data_word;
                predicted.is_key_word = 1'b1;
            end
            else
            begin
                key = keys[data_pos];
                if (direction == DIR_ENCRYPT)
                begin
                    predicted.out_word = word_in.data_word + key;
                end
                else
                begin
                    predicted.out_word = word_in.data_word - key;
                end
                predicted.is_key_word = 1'b0;
                if (data_pos == 2'd3)
                begin
                    rotate_keys();
                end
                data_pos = data_pos + 2'd1;
            end
            pending_words.push_back(predicted);
        endfunction

        // Compare one result transaction with the oldest prediction.
        function void check_word(input out_item_t got);
            out_item_t want;
            if (pending_words.size() == 0)
            begin
                $error("unexpected result: out_word=%h is_key_word=%b out_last=%b",
                       got.out_word, got.is_key_word, got.out_last);
                errors++;
                return;
            end
            want = pending_words.pop_front();
            if (got.out_word !== want.out_word)
            begin
                $error("out_word: expected %h, actual %h", want.out_word, got.out_word);
                errors++;
            end
            if (got.is_key_word !== want.is_key_word)
            begin
                $error("is_key_word: expected %b, actual %b", want.is_key_word,
                       got.is_key_word);
                errors++;
            end
            if (got.out_last !== want.out_last)
            begin
                $error("out_last: expected %b, actual %b", want.out_last, got.out_last);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;
    int   cycle_count = 0;
    int   words_sent = 0;
    int   burst_left = 0;

    kwsc_in_if  din_if ();
    kwsc_out_if dout_if ();

    word_cipher_scoreboard sb = new();

    keyed_word_stream_cipher_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .din       (din_if),
        .dout      (dout_if),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Clock generation.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Pick a word, favoring the extremes of the range.
    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            3: return 16'h7FFF;
            default: return WORD_W'($urandom);
        endcase
    endfunction

    // Offer one word and wait for the transaction; the sender may idle between bursts.
    task automatic push_word(input logic [WORD_W-1:0] word, input logic first,
                             input logic last);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 2) != 0)
            begin
                gap = $urandom_range(1, 6);
            end
        end
        burst_left--;
        if (gap > 0)
        begin
            din_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        din_if.valid <= 1'b1;
        din_if.data_word <= word;
        din_if.first_word <= first;
        din_if.in_last <= last;
        do
            @(posedge clk);
        while (!din_if.ready);
        sb.note_word(in_item_t'{word, first, last});
        words_sent++;
    endtask

    // One structure: four keys, then data words, with occasional stray marks.
    task automatic send_structure(input int data_len, input bit marked);
        int  total;
        bit  first;
        bit  last;
        total = KEY_COUNT + data_len;
        for (int i = 0; i < total; i++)
        begin
            first = (i == 0) ? marked : ($urandom_range(0, 39) == 0);
            last = (i == total - 1) ? 1'b1 : ($urandom_range(0, 29) == 0);
            push_word(pick_word(), first, last);
        end
    endtask

    // Stop sending and let every outstanding result drain.
    task automatic quiesce();
        din_if.valid <= 1'b0;
        while (sb.outstanding() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_direction(input logic dir);
        cfg_wdata <= dir;
        cfg_we <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_direction(dir);
    endtask

    // Receiver: ready follows a random mode that is picked anew whenever its run ends.
    initial
    begin : receiver
        int rx_mode;
        int rx_left;
        rx_mode = 0;
        rx_left = 0;
        dout_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_left == 0)
            begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(8, 80);
            end
            rx_left--;
            case (rx_mode)
                0: dout_if.ready <= 1'b1;
                1: dout_if.ready <= 1'($urandom_range(0, 1));
                2: dout_if.ready <= ($urandom_range(0, 3) == 0);
                default: dout_if.ready <= rx_left[2];
            endcase
        end
    end

    // Check every result transaction.
    always @(posedge clk)
    begin
        if (rst_n && dout_if.valid && dout_if.ready)
        begin
            sb.check_word(out_item_t'{dout_if.out_word, dout_if.is_key_word,
                                      dout_if.out_last});
        end
    end

    // Watchdog on the total run length.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int phase_start;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= 1'b0;
        din_if.valid <= 1'b0;
        din_if.data_word <= '0;
        din_if.first_word <= 1'b0;
        din_if.in_last <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Decrypt from reset: keys are taken without any first mark.
        push_word(16'hFFFF, 1'b0, 1'b0);
        push_word(16'h0000, 1'b0, 1'b0);
        push_word(16'h8000, 1'b0, 1'b0);
        push_word(16'h0001, 1'b0, 1'b0);
        push_word(16'h0000, 1'b0, 1'b0);
        push_word(16'hFFFF, 1'b0, 1'b0);
        push_word(16'h1234, 1'b0, 1'b0);
        push_word(16'h7FFF, 1'b0, 1'b0);
        push_word(16'h8000, 1'b0, 1'b0);
        push_word(16'hFFFF, 1'b0, 1'b0);
        push_word(16'h0000, 1'b0, 1'b0);
        push_word(16'h5A5A, 1'b0, 1'b1);
        // Words after the last mark continue the same structure.
        push_word(16'hA5A5, 1'b0, 1'b0);
        quiesce();

        // Encrypt, with a header cut short by a second first mark.
        write_direction(DIR_ENCRYPT);
        push_word(16'hFFFF, 1'b1, 1'b0);
        push_word(16'hABCD, 1'b0, 1'b0);
        push_word(16'h0001, 1'b1, 1'b0);
        push_word(16'hFFFE, 1'b0, 1'b0);
        push_word(16'h8000, 1'b0, 1'b0);
        push_word(16'h7FFF, 1'b0, 1'b0);
        push_word(16'hFFFF, 1'b0, 1'b0);
        push_word(16'h0002, 1'b0, 1'b0);
        push_word(16'h8001, 1'b0, 1'b1);
        push_word(16'h0000, 1'b1, 1'b1);

        // Random phases alternate the direction.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            quiesce();
            write_direction(ph[0] ? DIR_ENCRYPT : DIR_DECRYPT);
            phase_start = words_sent;
            while (words_sent - phase_start < PHASE_WORDS)
            begin
                case ($urandom_range(0, 9))
                    0:
                    begin
                        repeat ($urandom_range(1, 8))
                            push_word(pick_word(), 1'($urandom_range(0, 1)),
                                      1'($urandom_range(0, 1)));
                    end
                    1: send_structure($urandom_range(20, 60), 1'b1);
                    2: send_structure($urandom_range(0, 12), 1'b0);
                    default: send_structure($urandom_range(0, 12), 1'b1);
                endcase
            end
        end

        quiesce();
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: keyed_word_stream_cipher_unit.f
rtl/kwsc_pkg.sv
rtl/kwsc_if.sv
rtl/kwsc_in_stage.sv
rtl/kwsc_key_unit.sv
rtl/keyed_word_stream_cipher_unit.sv
sim/tb_keyed_word_stream_cipher_unit.sv
